### sv/hre_pkg.sv
`timescale 1ns / 1ps

package hre_pkg;

  localparam int CH_W     = 32;
  localparam int BYTE_W   = 8;
  localparam int FRAC_W   = 16;
  localparam int NUM_W    = BYTE_W + FRAC_W;
  localparam int DIV_BITS = BYTE_W;
  localparam int CMP_W    = CH_W + DIV_BITS;
  localparam int PROD_W   = CH_W + BYTE_W;
  // max stage, one cell per quotient bit, output stage
  localparam int LATENCY  = DIV_BITS + 2;

  localparam logic [BYTE_W-1:0] BYTE_MAX  = {BYTE_W{1'b1}};
  localparam logic [BYTE_W-1:0] BYTE_ONE  = {{(BYTE_W-1){1'b0}}, 1'b1};
  localparam logic [BYTE_W-1:0] BYTE_ZERO = '0;
  // 255 in UQ8.16
  localparam logic [NUM_W-1:0] NUMERATOR = {BYTE_MAX, {FRAC_W{1'b0}}};
  // quotient reaches 256 or more when the max is at most 255/256
  localparam logic [CH_W-1:0] SAT_LIMIT = {{(CH_W-FRAC_W){1'b0}}, BYTE_MAX, {BYTE_W{1'b0}}};

  typedef struct packed {
    logic              valid;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   hmax;
    logic [NUM_W-1:0]  rem;
    logic [BYTE_W-1:0] quo;
    logic              sat;
  } hre_cell_t;

endpackage

### sv/hre_max_stage.sv
`timescale 1ns / 1ps

module hre_max_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic [hre_pkg::CH_W-1:0] red,
  input  logic [hre_pkg::CH_W-1:0] green,
  input  logic [hre_pkg::CH_W-1:0] blue,
  output hre_pkg::hre_cell_t       cell_o
);

  logic [hre_pkg::CH_W-1:0] rg_max;
  logic [hre_pkg::CH_W-1:0] hmax;
  logic                     valid_r;
  hre_pkg::hre_cell_t       data_r;
  hre_pkg::hre_cell_t       data_nxt;

  assign rg_max = (green > red) ? green : red;
  assign hmax   = (blue > rg_max) ? blue : rg_max;

  always_comb begin
    data_nxt       = data_r;
    data_nxt.valid = 1'b0;
    data_nxt.red   = red;
    data_nxt.green = green;
    data_nxt.blue  = blue;
    data_nxt.hmax  = hmax;
    data_nxt.rem   = hre_pkg::NUMERATOR;
    data_nxt.quo   = hre_pkg::BYTE_ZERO;
    data_nxt.sat   = (hmax <= hre_pkg::SAT_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
    data_r <= data_nxt;
  end

  always_comb begin
    cell_o       = data_r;
    cell_o.valid = valid_r;
  end

endmodule

### sv/hre_div_cell.sv
`timescale 1ns / 1ps

module hre_div_cell #(
  parameter int BIT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hre_pkg::hre_cell_t cell_i,
  output hre_pkg::hre_cell_t cell_o
);

  localparam logic [$clog2(hre_pkg::BYTE_W)-1:0] QBIT = BIT[$clog2(hre_pkg::BYTE_W)-1:0];

  logic [hre_pkg::CMP_W-1:0] div_sh;
  logic [hre_pkg::CMP_W-1:0] rem_ext;
  logic [hre_pkg::CMP_W-1:0] diff;
  logic                      ge;
  logic                      valid_r;
  hre_pkg::hre_cell_t        data_r;
  hre_pkg::hre_cell_t        data_nxt;

  // trial subtract of the max shifted to this quotient bit
  assign div_sh  = {{hre_pkg::DIV_BITS{1'b0}}, cell_i.hmax} << BIT;
  assign rem_ext = {{(hre_pkg::CMP_W-hre_pkg::NUM_W){1'b0}}, cell_i.rem};
  assign diff    = rem_ext - div_sh;
  assign ge      = (rem_ext >= div_sh);

  always_comb begin
    data_nxt = cell_i;
    if (ge) begin
      data_nxt.rem = diff[hre_pkg::NUM_W-1:0];
    end
    data_nxt.quo[QBIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_i.valid;
    end
    data_r <= data_nxt;
  end

  always_comb begin
    cell_o       = data_r;
    cell_o.valid = valid_r;
  end

endmodule

### sv/hre_out_stage.sv
`timescale 1ns / 1ps

module hre_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hre_pkg::hre_cell_t         cell_i,
  output logic                       valid,
  output logic [hre_pkg::BYTE_W-1:0] red_byte,
  output logic [hre_pkg::BYTE_W-1:0] green_byte,
  output logic [hre_pkg::BYTE_W-1:0] blue_byte,
  output logic [hre_pkg::BYTE_W-1:0] scale_byte
);

  logic [hre_pkg::BYTE_W-1:0] scale;
  logic [hre_pkg::PROD_W-1:0] prod_red;
  logic [hre_pkg::PROD_W-1:0] prod_green;
  logic [hre_pkg::PROD_W-1:0] prod_blue;
  logic                       valid_r;
  logic [hre_pkg::BYTE_W-1:0] red_r;
  logic [hre_pkg::BYTE_W-1:0] green_r;
  logic [hre_pkg::BYTE_W-1:0] blue_r;
  logic [hre_pkg::BYTE_W-1:0] scale_r;
  logic [hre_pkg::BYTE_W-1:0] red_nxt;
  logic [hre_pkg::BYTE_W-1:0] green_nxt;
  logic [hre_pkg::BYTE_W-1:0] blue_nxt;

  // clamp quotient to 1..255
  always_comb begin
    if (cell_i.sat) begin
      scale = hre_pkg::BYTE_MAX;
    end else if (cell_i.quo == hre_pkg::BYTE_ZERO) begin
      scale = hre_pkg::BYTE_ONE;
    end else begin
      scale = cell_i.quo;
    end
  end

  assign prod_red   = {{hre_pkg::BYTE_W{1'b0}}, cell_i.red}   * {{hre_pkg::CH_W{1'b0}}, scale};
  assign prod_green = {{hre_pkg::BYTE_W{1'b0}}, cell_i.green} * {{hre_pkg::CH_W{1'b0}}, scale};
  assign prod_blue  = {{hre_pkg::BYTE_W{1'b0}}, cell_i.blue}  * {{hre_pkg::CH_W{1'b0}}, scale};

  // drop fraction, saturate integer part
  always_comb begin
    red_nxt   = (|prod_red[hre_pkg::PROD_W-1:hre_pkg::NUM_W]) ? hre_pkg::BYTE_MAX
                : prod_red[hre_pkg::NUM_W-1:hre_pkg::FRAC_W];
    green_nxt = (|prod_green[hre_pkg::PROD_W-1:hre_pkg::NUM_W]) ? hre_pkg::BYTE_MAX
                : prod_green[hre_pkg::NUM_W-1:hre_pkg::FRAC_W];
    blue_nxt  = (|prod_blue[hre_pkg::PROD_W-1:hre_pkg::NUM_W]) ? hre_pkg::BYTE_MAX
                : prod_blue[hre_pkg::NUM_W-1:hre_pkg::FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_i.valid;
    end
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    scale_r <= scale;
  end

  assign valid      = valid_r;
  assign red_byte   = red_r;
  assign green_byte = green_r;
  assign blue_byte  = blue_r;
  assign scale_byte = scale_r;

endmodule

### sv/hdr_rgb_to_rgbd_encoder.sv
`timescale 1ns / 1ps

// channel   ports                                   width     handshake
// request   in_red, in_green, in_blue               3 x 32    start high, busy low
// result    out_red_byte, out_green_byte,           4 x 8     out_valid strobe, one cycle
//           out_blue_byte, out_scale_byte
//
// one pixel accepted every cycle, busy never rises
// each result passes through one max register, one divider cell per scale
//   bit (eight), and one multiply and saturate register
// synchronous active-low reset clears only the valid bits of the chain
// the receiver cannot stall, so the chain advances every cycle

module hdr_rgb_to_rgbd_encoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [hre_pkg::CH_W-1:0]   in_red,
  input  logic [hre_pkg::CH_W-1:0]   in_green,
  input  logic [hre_pkg::CH_W-1:0]   in_blue,
  output logic                       out_valid,
  output logic [hre_pkg::BYTE_W-1:0] out_red_byte,
  output logic [hre_pkg::BYTE_W-1:0] out_green_byte,
  output logic [hre_pkg::BYTE_W-1:0] out_blue_byte,
  output logic [hre_pkg::BYTE_W-1:0] out_scale_byte
);

  // chain[0] is the max stage output, chain[k] the output of the k-th divider cell
  hre_pkg::hre_cell_t chain [hre_pkg::DIV_BITS+1];

  // fully pipelined, never holds requests off
  assign busy = 1'b0;

  // largest channel, saturation flag and initial remainder
  hre_max_stage u_max (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (start && !busy),
    .red    (in_red),
    .green  (in_green),
    .blue   (in_blue),
    .cell_o (chain[0])
  );

  // restoring division of 255.0 by the max, one quotient bit per cell, msb first
  for (genvar k = 0; k < hre_pkg::DIV_BITS; k++) begin : g_cell
    hre_div_cell #(
      .BIT (hre_pkg::DIV_BITS - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  // clamp scale, multiply channels and saturate to bytes
  hre_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_i     (chain[hre_pkg::DIV_BITS]),
    .valid      (out_valid),
    .red_byte   (out_red_byte),
    .green_byte (out_green_byte),
    .blue_byte  (out_blue_byte),
    .scale_byte (out_scale_byte)
  );

`ifndef SYNTHESIS
  // every request comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(hre_pkg::LATENCY) out_valid)
    else $error("request lost in the cell chain");

  // no result without a request at the matching time
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, hre_pkg::LATENCY))
    else $error("result without a request");

  // scale is clamped away from zero
  a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_scale_byte != hre_pkg::BYTE_ZERO))
    else $error("scale byte is zero");

  // a black pixel gives full scale and zero colors
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_red == '0 && in_green == '0 && in_blue == '0)
      |-> ##(hre_pkg::LATENCY) (out_scale_byte == hre_pkg::BYTE_MAX
                                && out_red_byte == hre_pkg::BYTE_ZERO))
    else $error("black pixel encoded wrong");
`endif

endmodule
